// ===== hw/rtl/range_min_segment_tree_assert.svh =====
// Assertion macros for the range minimum segment tree.
// Sampled on clk, disabled while rst_n is low; no other dependencies.
`ifndef RANGE_MIN_SEGMENT_TREE_ASSERT_SVH
`define RANGE_MIN_SEGMENT_TREE_ASSERT_SVH
`ifndef ASSERT_OFF
`define RMST_ASSERT_IMP(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("rmst assertion failed");
`define RMST_ASSERT_NXT(name, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("rmst assertion failed");
`else
`define RMST_ASSERT_IMP(name, pre, post)
`define RMST_ASSERT_NXT(name, pre, post)
`endif
`endif

// ===== hw/rtl/rmst_pkg.sv =====
// Package for the range minimum segment tree: value and result types,
// opcodes, state encoding and the signed minimum helper. No dependencies.
`timescale 1ns / 1ps
package rmst_pkg;

  localparam int IN_IDX_W = 11;
  localparam int VAL_W    = 32;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t MAX_VAL = 32'sh7FFF_FFFF;

  localparam logic OP_SET   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET,
    ST_QWALK,
    ST_QOUT
  } state_t;

  typedef struct packed {
    logic valid;
    val_t min_value;
    logic range_error;
  } res_t;

  function automatic val_t min_of(input val_t a, input val_t b);
    return (a < b) ? a : b;
  endfunction

endpackage

// ===== hw/rtl/rmst_mem.sv =====
// Node memory of the segment tree: one write port, two read ports,
// registered read data. Depends on rmst_pkg for the value type.
`timescale 1ns / 1ps
module rmst_mem #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                clk,
  input  logic                wr_en,
  input  logic [AW-1:0]       wr_addr,
  input  rmst_pkg::val_t      wr_data,
  input  logic [AW-1:0]       rd_addr0,
  input  logic [AW-1:0]       rd_addr1,
  output rmst_pkg::val_t      rd_data0,
  output rmst_pkg::val_t      rd_data1
);

  rmst_pkg::val_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data0 <= mem[rd_addr0];
    rd_data1 <= mem[rd_addr1];
  end

endmodule

// ===== hw/rtl/rmst_ctrl.sv =====
// Sequencer of the segment tree: clearing pass, leaf update with repair
// toward the root, and the bottom-up range walk. Uses rmst_pkg, drives rmst_mem.
`timescale 1ns / 1ps
module rmst_ctrl #(
  parameter int LEAF_COUNT = 1024,
  parameter int AW         = 11
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [rmst_pkg::IN_IDX_W-1:0]       in_position,
  input  rmst_pkg::val_t                      in_new_value,
  input  logic [rmst_pkg::IN_IDX_W-1:0]       in_left_bound,
  input  logic [rmst_pkg::IN_IDX_W-1:0]       in_right_bound,
  output rmst_pkg::res_t                      res,
  input  logic                                res_ready,
  output logic                                wr_en,
  output logic [AW-1:0]                       wr_addr,
  output rmst_pkg::val_t                      wr_data,
  output logic [AW-1:0]                       rd_addr0,
  output logic [AW-1:0]                       rd_addr1,
  input  rmst_pkg::val_t                      rd_data0,
  input  rmst_pkg::val_t                      rd_data1
);

  localparam int NW    = AW + 1;
  localparam int CW    = (NW > rmst_pkg::IN_IDX_W) ? NW : rmst_pkg::IN_IDX_W;
  localparam int DEPTH = 2 * LEAF_COUNT;

  localparam logic [CW-1:0] LC_C    = CW'(LEAF_COUNT);
  localparam logic [CW-1:0] ONE_C   = CW'(1);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);
  localparam logic [AW-1:0] ROOT_A  = AW'(1);

  rmst_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic [AW-1:0]    node_r, node_nxt;
  rmst_pkg::val_t   cur_r, cur_nxt;
  logic [NW-1:0]    lo_r, lo_nxt;
  logic [NW-1:0]    hi_r, hi_nxt;
  logic             take0_r, take0_nxt;
  logic             take1_r, take1_nxt;
  rmst_pkg::val_t   best_r, best_nxt;
  logic             err_r, err_nxt;

  logic [CW-1:0]    pos_x, left_x, right_x, left_c, right_c;
  logic [CW-1:0]    leaf_x, lo_x, hi_x;
  logic [AW-1:0]    leaf;
  logic             set_ok, rev, empty;
  rmst_pkg::val_t   m, merged;
  logic [NW-1:0]    hi_m1, lo_p;

  always_comb begin
    pos_x   = CW'(in_position);
    left_x  = CW'(in_left_bound);
    right_x = CW'(in_right_bound);
    set_ok  = (pos_x != '0) && (pos_x <= LC_C);
    leaf_x  = LC_C + pos_x - ONE_C;
    leaf    = leaf_x[AW-1:0];
    left_c  = (left_x == '0) ? ONE_C : left_x;
    right_c = (right_x > LC_C) ? LC_C : right_x;
    rev     = in_left_bound > in_right_bound;
    empty   = left_c > right_c;
    lo_x    = LC_C + left_c - ONE_C;
    hi_x    = LC_C + right_c;
    m       = rmst_pkg::min_of(cur_r, rd_data0);
    hi_m1   = hi_r - NW'(1);
    lo_p    = lo_r + NW'(lo_r[0]);
    merged  = best_r;
    if (take0_r) begin
      merged = rmst_pkg::min_of(merged, rd_data0);
    end
    if (take1_r) begin
      merged = rmst_pkg::min_of(merged, rd_data1);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    clr_cnt_nxt = clr_cnt_r;
    node_nxt    = node_r;
    cur_nxt     = cur_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    take0_nxt   = take0_r;
    take1_nxt   = take1_r;
    best_nxt    = best_r;
    err_nxt     = err_r;
    wr_en       = 1'b0;
    wr_addr     = node_r;
    wr_data     = m;
    rd_addr0    = '0;
    rd_addr1    = '0;
    in_ready    = 1'b0;
    res.valid       = 1'b0;
    res.min_value   = best_r;
    res.range_error = err_r;
    unique case (state_r)
      rmst_pkg::ST_CLEAR: begin
        wr_en       = 1'b1;
        wr_addr     = clr_cnt_r;
        wr_data     = rmst_pkg::MAX_VAL;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == LAST_A) begin
          state_nxt = rmst_pkg::ST_IDLE;
        end
      end
      rmst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_opcode == rmst_pkg::OP_SET) begin
            if (set_ok) begin
              wr_en     = 1'b1;
              wr_addr   = leaf;
              wr_data   = in_new_value;
              rd_addr0  = {leaf[AW-1:1], ~leaf[0]};
              rd_addr1  = leaf >> 1;
              node_nxt  = leaf >> 1;
              cur_nxt   = in_new_value;
              state_nxt = rmst_pkg::ST_SET;
            end
          end else begin
            best_nxt  = rmst_pkg::MAX_VAL;
            err_nxt   = 1'b0;
            take0_nxt = 1'b0;
            take1_nxt = 1'b0;
            if (rev) begin
              err_nxt   = 1'b1;
              state_nxt = rmst_pkg::ST_QOUT;
            end else if (empty) begin
              state_nxt = rmst_pkg::ST_QOUT;
            end else begin
              lo_nxt    = lo_x[NW-1:0];
              hi_nxt    = hi_x[NW-1:0];
              state_nxt = rmst_pkg::ST_QWALK;
            end
          end
        end
      end
      rmst_pkg::ST_SET: begin
        // rd_data0: sibling of the updated child, rd_data1: parent
        if (m == rd_data1) begin
          state_nxt = rmst_pkg::ST_IDLE;
        end else begin
          wr_en   = 1'b1;
          wr_addr = node_r;
          wr_data = m;
          if (node_r == ROOT_A) begin
            state_nxt = rmst_pkg::ST_IDLE;
          end else begin
            rd_addr0 = {node_r[AW-1:1], ~node_r[0]};
            rd_addr1 = node_r >> 1;
            node_nxt = node_r >> 1;
            cur_nxt  = m;
          end
        end
      end
      rmst_pkg::ST_QWALK: begin
        best_nxt = merged;
        if (lo_r < hi_r) begin
          rd_addr0  = lo_r[AW-1:0];
          rd_addr1  = hi_m1[AW-1:0];
          take0_nxt = lo_r[0];
          take1_nxt = hi_r[0];
          lo_nxt    = lo_p >> 1;
          hi_nxt    = (hi_r[0] ? hi_m1 : hi_r) >> 1;
        end else begin
          take0_nxt = 1'b0;
          take1_nxt = 1'b0;
          state_nxt = rmst_pkg::ST_QOUT;
        end
      end
      rmst_pkg::ST_QOUT: begin
        res.valid = 1'b1;
        if (res_ready) begin
          state_nxt = rmst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rmst_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= rmst_pkg::ST_CLEAR;
      clr_cnt_r <= '0;
      take0_r   <= 1'b0;
      take1_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      take0_r   <= take0_nxt;
      take1_r   <= take1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r <= node_nxt;
    cur_r  <= cur_nxt;
    lo_r   <= lo_nxt;
    hi_r   <= hi_nxt;
    best_r <= best_nxt;
    err_r  <= err_nxt;
  end

endmodule

// ===== hw/rtl/range_min_segment_tree.sv =====
// Channel  Ports                                                     Direction
// in       in_valid/in_ready, opcode, position, new_value, bounds    request in
// out      out_valid/out_ready, min_value, range_error               result out
//
// After reset a clearing pass writes all 2*LEAF_COUNT nodes, one per cycle,
// with in_ready low. A set writes the leaf and repairs toward the root one tree
// level per step, stopping early once a parent is unchanged. A query walks the
// range bottom-up, one tree level per step, merging the boundary nodes.
// The output register lets a new request enter while a result waits.
// Top level of the range minimum segment tree; uses rmst_pkg, rmst_mem,
// rmst_ctrl and the assertion macro header.
`timescale 1ns / 1ps
`include "range_min_segment_tree_assert.svh"
module range_min_segment_tree #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_opcode,
  input  logic [rmst_pkg::IN_IDX_W-1:0]       in_position,
  input  rmst_pkg::val_t                      in_new_value,
  input  logic [rmst_pkg::IN_IDX_W-1:0]       in_left_bound,
  input  logic [rmst_pkg::IN_IDX_W-1:0]       in_right_bound,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rmst_pkg::val_t                      out_min_value,
  output logic                                out_range_error
);

  localparam int DEPTH = 2 * LEAF_COUNT;
  localparam int AW    = $clog2(DEPTH);

  rmst_pkg::res_t  res;
  logic            res_ready;
  logic            wr_en;
  logic [AW-1:0]   wr_addr, rd_addr0, rd_addr1;
  rmst_pkg::val_t  wr_data, rd_data0, rd_data1;

  logic            out_valid_r, out_valid_nxt;
  rmst_pkg::val_t  out_min_value_r;
  logic            out_range_error_r;

  rmst_ctrl #(
    .LEAF_COUNT (LEAF_COUNT),
    .AW         (AW)
  ) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_position    (in_position),
    .in_new_value   (in_new_value),
    .in_left_bound  (in_left_bound),
    .in_right_bound (in_right_bound),
    .res            (res),
    .res_ready      (res_ready),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .rd_addr0       (rd_addr0),
    .rd_addr1       (rd_addr1),
    .rd_data0       (rd_data0),
    .rd_data1       (rd_data1)
  );

  rmst_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk      (clk),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_addr0 (rd_addr0),
    .rd_addr1 (rd_addr1),
    .rd_data0 (rd_data0),
    .rd_data1 (rd_data1)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res.valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid && res_ready) begin
      out_min_value_r   <= res.min_value;
      out_range_error_r <= res.range_error;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_min_value   = out_min_value_r;
  assign out_range_error = out_range_error_r;

  `RMST_ASSERT_NXT(a_res_hold, res.valid && !res_ready, res.valid && $stable(res.min_value))
  `RMST_ASSERT_NXT(a_query_busy, in_valid && in_ready && in_opcode == rmst_pkg::OP_QUERY, !in_ready)
  `RMST_ASSERT_IMP(a_err_max, res.valid && res.range_error, res.min_value == rmst_pkg::MAX_VAL)
  `RMST_ASSERT_IMP(a_no_load_full, out_valid_r && !out_ready, !(res.valid && res_ready))

endmodule

// ===== tb/range_min_checker.sv =====
`timescale 1ns / 1ps
// Checker for range_min_segment_tree: keeps its own copy of the min-tree from accepted
// requests, predicts each query result and compares it with the out channel.
// Depends on rmst_pkg.
module range_min_checker #(
  parameter int LEAF_COUNT = 1024
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic                          in_opcode,
  input  logic [rmst_pkg::IN_IDX_W-1:0] in_position,
  input  rmst_pkg::val_t                in_new_value,
  input  logic [rmst_pkg::IN_IDX_W-1:0] in_left_bound,
  input  logic [rmst_pkg::IN_IDX_W-1:0] in_right_bound,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  rmst_pkg::val_t                out_min_value,
  input  logic                          out_range_error,
  output int                            mismatches,
  output int                            outstanding
);
  import rmst_pkg::*;

  typedef struct packed {
    val_t min_value;
    logic range_error;
  } min_result_t;

  val_t        tree_nodes [1:2*LEAF_COUNT-1];
  min_result_t expected_minima [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 30) begin
      $display("%0t range_min_checker: %s", $time, what);
    end
  endtask

  task automatic apply_leaf_write(input logic [IN_IDX_W-1:0] pos, input val_t value);
    int   node;
    val_t smaller;
    if (pos == 0 || pos > LEAF_COUNT) return;
    node = LEAF_COUNT + int'(pos) - 1;
    tree_nodes[node] = value;
    node = node >> 1;
    while (node >= 1) begin
      smaller = (tree_nodes[2*node] < tree_nodes[2*node+1]) ? tree_nodes[2*node]
                                                            : tree_nodes[2*node+1];
      if (smaller == tree_nodes[node]) break;
      tree_nodes[node] = smaller;
      node = node >> 1;
    end
  endtask

  function automatic min_result_t predict_range_min(input logic [IN_IDX_W-1:0] lo_bound,
                                                    input logic [IN_IDX_W-1:0] hi_bound);
    min_result_t res;
    int          lo;
    int          hi;
    val_t        best;
    best = MAX_VAL;
    res.range_error = 1'b0;
    if (lo_bound > hi_bound) begin
      res.min_value   = MAX_VAL;
      res.range_error = 1'b1;
      return res;
    end
    lo = (lo_bound == 0) ? 1 : int'(lo_bound);
    hi = (int'(hi_bound) > LEAF_COUNT) ? LEAF_COUNT : int'(hi_bound);
    if (lo <= hi) begin
      lo = LEAF_COUNT + lo - 1;
      hi = LEAF_COUNT + hi;
      while (lo < hi) begin
        if (lo[0]) begin
          if (tree_nodes[lo] < best) best = tree_nodes[lo];
          lo++;
        end
        if (hi[0]) begin
          hi--;
          if (tree_nodes[hi] < best) best = tree_nodes[hi];
        end
        lo = lo >> 1;
        hi = hi >> 1;
      end
    end
    res.min_value = best;
    return res;
  endfunction

  always @(posedge clk) begin : track
    min_result_t want;
    if (!rst_n) begin
      for (int n = 1; n < 2*LEAF_COUNT; n++) tree_nodes[n] = MAX_VAL;
      expected_minima.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_minima.size() == 0) begin
          report_mismatch("result with no query pending");
        end else begin
          want = expected_minima.pop_front();
          if (out_min_value !== want.min_value) begin
            report_mismatch($sformatf("min_value %0d, expected %0d",
                                      out_min_value, want.min_value));
          end
          if (out_range_error !== want.range_error) begin
            report_mismatch($sformatf("range_error %b, expected %b",
                                      out_range_error, want.range_error));
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_opcode == OP_SET) begin
          apply_leaf_write(in_position, in_new_value);
        end else begin
          expected_minima.push_back(predict_range_min(in_left_bound, in_right_bound));
        end
      end
    end
    outstanding = expected_minima.size();
  end

endmodule

// ===== tb/range_min_segment_tree_tb.sv =====
`timescale 1ns / 1ps
// Testbench top for range_min_segment_tree: drives directed and random set/query
// requests with random idling on both channels and gives the verdict.
// Depends on rmst_pkg, range_min_checker and the block under test.
module range_min_segment_tree_tb;
  import rmst_pkg::*;

  localparam int   LEAF_COUNT = 1024;
  localparam val_t MIN_VAL    = 32'sh8000_0000;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic                in_opcode;
  logic [IN_IDX_W-1:0] in_position;
  val_t                in_new_value;
  logic [IN_IDX_W-1:0] in_left_bound;
  logic [IN_IDX_W-1:0] in_right_bound;
  logic                out_valid;
  logic                out_ready;
  val_t                out_min_value;
  logic                out_range_error;
  int                  mismatches;
  int                  outstanding;
  bit                  tx_idle_on = 1'b1;
  bit                  rx_idle_on = 1'b1;

  range_min_segment_tree #(.LEAF_COUNT(LEAF_COUNT)) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_position    (in_position),
    .in_new_value   (in_new_value),
    .in_left_bound  (in_left_bound),
    .in_right_bound (in_right_bound),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_min_value  (out_min_value),
    .out_range_error(out_range_error)
  );

  range_min_checker #(.LEAF_COUNT(LEAF_COUNT)) u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_position    (in_position),
    .in_new_value   (in_new_value),
    .in_left_bound  (in_left_bound),
    .in_right_bound (in_right_bound),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_min_value  (out_min_value),
    .out_range_error(out_range_error),
    .mismatches     (mismatches),
    .outstanding    (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("range_min_segment_tree_tb: FAIL");
    $finish;
  end

  function automatic int idle_cycles();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(0, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic val_t pick_value();
    case ($urandom_range(0, 9))
      0:       return MAX_VAL;
      1:       return MIN_VAL;
      2, 3, 4: return val_t'($urandom_range(0, 40)) - 20;
      default: return val_t'($urandom);
    endcase
  endfunction

  task automatic issue_request(input logic op, input int pos, input val_t value,
                               input int lb, input int rb);
    int gap;
    gap = tx_idle_on ? idle_cycles() : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid       <= 1'b1;
    in_opcode      <= op;
    in_position    <= pos[IN_IDX_W-1:0];
    in_new_value   <= value;
    in_left_bound  <= lb[IN_IDX_W-1:0];
    in_right_bound <= rb[IN_IDX_W-1:0];
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic pause_until_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  // result side: random stalls, off during quiet stretches
  initial begin : result_sink
    int hold;
    out_ready = 1'b1;
    forever begin
      @(negedge clk);
      if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        hold = idle_cycles() + 1;
        repeat (hold) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  initial begin : stimulus
    int useful;
    int next_pause;
    int next_mode;
    int kind;
    int pos;
    int lb;
    int rb;
    int span;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_SET;
    in_position    = '0;
    in_new_value   = '0;
    in_left_bound  = '0;
    in_right_bound = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed
    issue_request(OP_QUERY, 0, 0, 1, LEAF_COUNT);
    issue_request(OP_SET, 1, MIN_VAL, 0, 0);
    issue_request(OP_SET, LEAF_COUNT, MAX_VAL, 0, 0);
    issue_request(OP_SET, 512, 0, 0, 0);
    issue_request(OP_SET, 0, -5, 0, 0);
    issue_request(OP_SET, 2047, -7, 2047, 2047);
    issue_request(OP_SET, LEAF_COUNT + 1, -9, 0, 0);
    issue_request(OP_QUERY, 0, 0, 1, 1);
    issue_request(OP_QUERY, 2047, -1, 2, LEAF_COUNT);
    issue_request(OP_QUERY, 0, 0, 5, 3);
    issue_request(OP_QUERY, 0, 0, 0, 1);
    issue_request(OP_QUERY, 0, 0, 0, 0);
    issue_request(OP_QUERY, 0, 0, 1000, 2047);
    issue_request(OP_QUERY, 0, 0, LEAF_COUNT + 1, 2047);
    issue_request(OP_QUERY, 0, 0, 2047, 2047);
    issue_request(OP_QUERY, 0, 0, 2047, 1);
    issue_request(OP_SET, 1, MAX_VAL, 0, 0);
    issue_request(OP_QUERY, 0, 0, 1, LEAF_COUNT);
    issue_request(OP_SET, 700, -1, 2047, 0);
    issue_request(OP_QUERY, 5, 123, 1, LEAF_COUNT);
    issue_request(OP_SET, 512, 5, 0, 0);
    issue_request(OP_QUERY, 0, 0, 500, 600);
    issue_request(OP_QUERY, 0, 0, LEAF_COUNT, LEAF_COUNT);
    issue_request(OP_QUERY, 0, 0, 1, 511);
    pause_until_drained();

    useful     = 0;
    next_pause = 120;
    next_mode  = 60;
    while (useful < 500) begin
      kind = $urandom_range(0, 99);
      if (kind < 48) begin
        pos = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 32)
                                          : $urandom_range(1, LEAF_COUNT);
        issue_request(OP_SET, pos, pick_value(), $urandom_range(0, 2047),
                      $urandom_range(0, 2047));
        useful++;
      end else if (kind < 90) begin
        lb = $urandom_range(1, LEAF_COUNT);
        case ($urandom_range(0, 3))
          0:       span = $urandom_range(0, 15);
          1:       span = $urandom_range(0, 200);
          2: begin
            lb   = $urandom_range(1, 8);
            span = LEAF_COUNT;
          end
          default: span = $urandom_range(0, LEAF_COUNT);
        endcase
        rb = (lb + span > LEAF_COUNT) ? LEAF_COUNT : lb + span;
        issue_request(OP_QUERY, $urandom_range(0, 2047), pick_value(), lb, rb);
        useful++;
      end else begin
        case ($urandom_range(0, 3))
          0: begin
            pos = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(LEAF_COUNT + 1, 2047);
            issue_request(OP_SET, pos, pick_value(), 0, 0);
          end
          1: begin
            rb = $urandom_range(0, 2046);
            lb = $urandom_range(rb + 1, 2047);
            issue_request(OP_QUERY, 0, 0, lb, rb);
            useful++;
          end
          2: begin
            issue_request(OP_QUERY, 0, 0, 0, $urandom_range(0, 2047));
            useful++;
          end
          default: begin
            issue_request(OP_QUERY, 0, 0, $urandom_range(1, 2047),
                          $urandom_range(LEAF_COUNT + 1, 2047));
            useful++;
          end
        endcase
      end
      if (useful >= next_pause) begin
        pause_until_drained();
        next_pause += 120;
      end
      if (useful >= next_mode) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        next_mode += 60;
      end
    end

    pause_until_drained();
    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("range_min_segment_tree_tb: PASS");
    end else begin
      $display("range_min_segment_tree_tb: FAIL");
    end
    $finish;
  end

endmodule
